### sv/wia_pkg.sv
// Shared types and operation codes for the wide integer ALU.
package wia_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_SHL = 3'd2,
		OP_SHR = 3'd3,
		OP_SRA = 3'd4,
		OP_MUL = 3'd5
	} op_t;

	localparam int HALF_W  = 64;
	localparam int MODE_W  = 3;
	localparam int SHAMT_W = 8;
	localparam int LIMB_W  = 32;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [HALF_W-1:0]  a_lo;
		logic [HALF_W-1:0]  a_hi;
		logic [HALF_W-1:0]  b_lo;
		logic [HALF_W-1:0]  b_hi;
		logic [SHAMT_W-1:0] shift_amount;
	} req_t;

	typedef struct packed {
		logic [HALF_W-1:0] res_lo;
		logic [HALF_W-1:0] res_hi;
	} rsp_t;

endpackage

### sv/wia_req_if.sv
// Valid/ready channel carrying one operand transaction.
interface wia_req_if;
	import wia_pkg::*;
	logic valid;
	logic ready;
	logic [MODE_W-1:0]  mode;
	logic [HALF_W-1:0]  a_lo;
	logic [HALF_W-1:0]  a_hi;
	logic [HALF_W-1:0]  b_lo;
	logic [HALF_W-1:0]  b_hi;
	logic [SHAMT_W-1:0] shift_amount;
	modport source (output valid, mode, a_lo, a_hi, b_lo, b_hi, shift_amount, input ready);
	modport sink (input valid, mode, a_lo, a_hi, b_lo, b_hi, shift_amount, output ready);
endinterface

### sv/wia_rsp_if.sv
// Valid/ready channel carrying one result transaction.
interface wia_rsp_if;
	import wia_pkg::*;
	logic valid;
	logic ready;
	logic [HALF_W-1:0] res_lo;
	logic [HALF_W-1:0] res_hi;
	modport source (output valid, res_lo, res_hi, input ready);
	modport sink (input valid, res_lo, res_hi, output ready);
endinterface

### sv/wia_mul.sv
// Four-stage multiplier keeping the low WIDTH bits of a WIDTH x WIDTH product.
module wia_mul #(
	parameter int WIDTH = 128
) (
	input  logic              clk,
	input  logic              en,
	input  logic [WIDTH-1:0]  a,
	input  logic [WIDTH-1:0]  b,
	output logic [WIDTH-1:0]  p
);
	import wia_pkg::*;

	localparam int NL = 4;	// 32-bit limbs covering up to 128 bits
	localparam int PW = 2 * LIMB_W;

	logic [NL*LIMB_W-1:0] ax, bx;
	logic [PW-1:0] pp_s1 [NL][NL];
	logic [WIDTH-1:0] row_s2 [NL];
	logic [WIDTH-1:0] sum_s3 [2];
	logic [WIDTH-1:0] p_s4;

	assign ax = (NL*LIMB_W)'(a);
	assign bx = (NL*LIMB_W)'(b);

	// Stage 1: limb partial products, one 32x32 multiply each where i + j < NL, zero otherwise.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++)
				for (int j = 0; j < NL; j++)
					pp_s1[i][j] <= (i + j < NL)
						? PW'(ax[i*LIMB_W +: LIMB_W]) * PW'(bx[j*LIMB_W +: LIMB_W])
						: '0;
		end
	end

	// Stage 2: sum each row of partial products, shifted into place.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++) begin
				logic [NL*LIMB_W+PW-1:0] acc;
				acc = '0;
				for (int j = 0; j < NL; j++)
					acc = acc + ((NL*LIMB_W+PW)'(pp_s1[i][j]) << ((i + j) * LIMB_W));
				row_s2[i] <= WIDTH'(acc);
			end
		end
	end

	// Stage 3: pairwise add; stage 4: final add.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3[0] <= row_s2[0] + row_s2[1];
			sum_s3[1] <= row_s2[2] + row_s2[3];
			p_s4 <= sum_s3[0] + sum_s3[1];
		end
	end

	assign p = p_s4;
endmodule

### sv/wide_integer_alu.sv
// Top level: pipelined WIDTH-bit add/subtract/shift/multiply unit.
//   channel | dir | fields
//   req     | in  | mode, a_lo, a_hi, b_lo, b_hi, shift_amount
//   rsp     | out | res_lo, res_hi
// Every transaction passes through the pipeline stages from acceptance to result; one may
// enter each cycle unless the output stalls. Depth is set by the four-stage multiplier; other modes ride along.
// arst_n clears all valid bits. A stalled output freezes the whole pipeline,
// which accepts again as soon as the last stage can move.
module wide_integer_alu #(
	parameter int WIDTH = 128
) (
	input logic clk,
	input logic arst_n,
	wia_req_if.sink req,
	wia_rsp_if.source rsp
);
	import wia_pkg::*;

	localparam int STAGES = 4;
	localparam int HW = WIDTH - HALF_W;

	logic              adv;
	logic [STAGES-1:0] vld_q;
	logic [WIDTH-1:0]  a, b, alu, mres;
	logic [WIDTH-1:0]  res_s1, res_s2, res_s3;
	logic              ismul_s1, ismul_s2, ismul_s3, ismul_s4;
	logic [WIDTH-1:0]  res_s4;
	logic [WIDTH-1:0]  res_out;
	logic              fill;
	logic [2*WIDTH-1:0] ext;

	assign adv = !vld_q[STAGES-1] || rsp.ready;
	assign req.ready = adv;

	assign a = {req.a_hi[HW-1:0], req.a_lo};
	assign b = {req.b_hi[HW-1:0], req.b_lo};
	assign fill = a[WIDTH-1];
	assign ext = {{WIDTH{fill}}, a};

	always_comb begin
		alu = '0;
		case (req.mode)
			OP_ADD: alu = a + b;
			OP_SUB: alu = a - b;
			OP_SHL: if (32'(req.shift_amount) < WIDTH) alu = a << req.shift_amount;
			OP_SHR: if (32'(req.shift_amount) < WIDTH) alu = a >> req.shift_amount;
			OP_SRA: alu = (32'(req.shift_amount) < WIDTH)
				? WIDTH'(ext >> req.shift_amount) : {WIDTH{fill}};
			default: alu = '0;
		endcase
	end

	wia_mul #(.WIDTH(WIDTH)) u_mul (.clk(clk), .en(adv), .a(a), .b(b), .p(mres));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1 <= alu;
			ismul_s1 <= (req.mode == OP_MUL);
			res_s2 <= res_s1;
			ismul_s2 <= ismul_s1;
			res_s3 <= res_s2;
			ismul_s3 <= ismul_s2;
			res_s4 <= res_s3;
			ismul_s4 <= ismul_s3;
		end
	end

	// The multiplier output register lines up with the last stage.
	assign res_out = ismul_s4 ? mres : res_s4;

	assign rsp.valid = vld_q[STAGES-1];
	assign rsp.res_lo = res_out[HALF_W-1:0];
	assign rsp.res_hi = HALF_W'(res_out[WIDTH-1:HALF_W]);
endmodule

### sv/wia_check.sv
// Port-level checker for the wide integer ALU, bound to the top level.
module wia_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] res_lo
);
	// An accepted transaction yields a valid result at the end of the pipeline when out_ready stays high in between.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");
	// Input is refused only while a result is held.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output stall");
	// A held result stays valid and keeps its low half.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_lo)))
		else $error("held result changed");
endmodule

bind wide_integer_alu wia_check u_check (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.res_lo(rsp.res_lo)
);
